// ----- design/cbd_pkg.sv -----
// shared types and constants for the cpu bus decoder
package cbd_pkg;

    typedef enum logic [1:0] {
        ACT_READ   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_BUTTON = 2'd3
    } act_t;

    typedef enum logic [2:0] {
        TGT_NONE = 3'd0,
        TGT_CART = 3'd1,
        TGT_RAM  = 3'd2,
        TGT_PPU  = 3'd3,
        TGT_PAD  = 3'd4,
        TGT_APU  = 3'd5,
        TGT_DMA  = 3'd6
    } tgt_t;

    localparam logic [15:0] RAM_TOP      = 16'h1FFF;
    localparam logic [15:0] PPU_TOP      = 16'h3FFF;
    localparam logic [15:0] APU_BASE     = 16'h4000;
    localparam logic [15:0] DMA_REG_ADDR = 16'h4014;
    localparam logic [15:0] APU_STATUS   = 16'h4015;
    localparam logic [15:0] PAD0_ADDR    = 16'h4016;
    localparam logic [15:0] PAD1_ADDR    = 16'h4017;
    localparam logic [4:0]  APU_STAT_OFF = 5'h15;
    localparam logic [7:0]  PAD_OPEN_BUS = 8'h40;
    localparam logic [7:0]  SHIFT_FILL   = 8'h80;
    localparam logic [2:0]  PHASE_A      = 3'd0;
    localparam logic [2:0]  PHASE_B      = 3'd3;
    localparam logic [2:0]  PHASE_LAST   = 3'd5;
    localparam logic [7:0]  DMA_LAST_OFF = 8'hFF;

    typedef struct packed {
        logic       rd;
        logic       port;
        logic       wr;
        logic       wbit;
        logic       upd;
        logic       idx;
        logic [7:0] mask;
        logic       pressed;
    } pad_req_t;

endpackage

// ----- design/cbd_ram.sv -----
// work ram with registered read and clearing pass after reset
module cbd_ram
    import cbd_pkg::*;
#(
    parameter int RAM_BYTES = 2048
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         we,
    input  logic [$clog2(RAM_BYTES)-1:0] addr,
    input  logic [7:0]                   wdata,
    output logic [7:0]                   q,
    output logic                         clearing
);

    localparam int AW = $clog2(RAM_BYTES);

    logic [7:0]  mem [RAM_BYTES];
    logic [AW:0] clr_reg;
    logic [AW:0] clr_next;
    logic [7:0]  q_reg;

    assign clearing = ~clr_reg[AW];
    assign clr_next = clr_reg + {{AW{1'b0}}, 1'b1};
    assign q        = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (clearing)
        begin
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            mem[clr_reg[AW-1:0]] <= 8'h00;
        end
        else if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            q_reg <= mem[addr];
        end
    end

endmodule

// ----- design/cbd_pads.sv -----
// two serial pad ports with button latches and shift registers
module cbd_pads
    import cbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pad_req_t req,
    output logic     rd_bit
);

    logic [7:0] buttons_reg [2];
    logic [7:0] buttons_next [2];
    logic [7:0] shift_reg [2];
    logic [7:0] shift_next [2];
    logic       strobe_reg;
    logic       strobe_next;

    always_comb
    begin
        buttons_next = buttons_reg;
        shift_next   = shift_reg;
        strobe_next  = strobe_reg;
        rd_bit       = strobe_reg ? buttons_reg[req.port][0] : shift_reg[req.port][0];
        if (req.rd && !strobe_reg)
        begin
            shift_next[req.port] = (shift_reg[req.port] >> 1) | SHIFT_FILL;
        end
        if (req.wr)
        begin
            strobe_next = req.wbit;
            if (req.wbit || strobe_reg)
            begin
                shift_next[0] = buttons_reg[0];
                shift_next[1] = buttons_reg[1];
            end
        end
        if (req.upd)
        begin
            if (req.pressed)
            begin
                buttons_next[req.idx] = buttons_reg[req.idx] | req.mask;
            end
            else
            begin
                buttons_next[req.idx] = buttons_reg[req.idx] & ~req.mask;
            end
            if (strobe_reg)
            begin
                shift_next[req.idx] = buttons_next[req.idx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buttons_reg[0] <= '0;
            buttons_reg[1] <= '0;
            shift_reg[0]   <= '0;
            shift_reg[1]   <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            buttons_reg <= buttons_next;
            shift_reg   <= shift_next;
            strobe_reg  <= strobe_next;
        end
    end

endmodule

// ----- design/cpu_bus_decoder_pads_oam_dma.sv -----
// top level: bus decode, tick sequencing, sprite dma and result register
//
// channel   direction  handshake               payload
// command   in         start high, busy low    action addr wdata pad_index button_mask
//                                              pressed ext_claim ext_data ppu_nmi
// result    out        done high one cycle     rdata target reg_offset cpu_step apu_step
//                                              oam_write_valid oam_write_data
//                                              dma_read_addr nmi_out
//
// one transaction per clock while busy is low; its result appears with done in the cycle after acceptance
// the work ram has a single port and its read data is registered
// after reset busy stays high while the ram is cleared
// reset is asynchronous and active low; the receiver cannot stall
module cpu_bus_decoder_pads_oam_dma
    import cbd_pkg::*;
#(
    parameter int RAM_BYTES = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [15:0] addr,
    input  logic [7:0]  wdata,
    input  logic        pad_index,
    input  logic [7:0]  button_mask,
    input  logic        pressed,
    input  logic        ext_claim,
    input  logic [7:0]  ext_data,
    input  logic        ppu_nmi,
    output logic        done,
    output logic [7:0]  rdata,
    output logic [2:0]  target,
    output logic [4:0]  reg_offset,
    output logic        cpu_step,
    output logic        apu_step,
    output logic        oam_write_valid,
    output logic [7:0]  oam_write_data,
    output logic [15:0] dma_read_addr,
    output logic        nmi_out
);

    localparam int AW = $clog2(RAM_BYTES);

    act_t       act;
    logic       acc;
    logic       dma_rd;
    logic       rd_go;
    logic       ram_rd;
    logic       ram_wr;
    logic [15:0] bus_a;
    logic [7:0] mem_q;
    logic       pad_bit;
    pad_req_t   pad_req;

    tgt_t       tgt_n;
    logic [4:0] off_n;
    logic [7:0] rdata_n;
    logic       cstep_n;
    logic       astep_n;
    logic       oamv_n;
    logic [7:0] oamd_n;
    logic [15:0] raddr_n;

    logic [2:0] phase_reg;
    logic [2:0] phase_next;
    logic [7:0] page_reg;
    logic [7:0] page_next;
    logic [7:0] offset_reg;
    logic [7:0] offset_next;
    logic [7:0] latch_reg;
    logic       active_reg;
    logic       active_next;
    logic       align_reg;
    logic       align_next;
    logic       fix_reg;

    logic       done_reg;
    logic       ram_sel_reg;
    logic [7:0] rdata_reg;
    tgt_t       tgt_reg;
    logic [4:0] off_reg;
    logic       cstep_reg;
    logic       astep_reg;
    logic       oamv_reg;
    logic [7:0] oamd_reg;
    logic [15:0] raddr_reg;
    logic       nmi_reg;

    assign act    = act_t'(action);
    assign acc    = start && !busy;
    assign ram_wr = (act == ACT_WRITE) && !ext_claim && (addr <= RAM_TOP);

    cbd_ram #(
        .RAM_BYTES(RAM_BYTES)
    ) u_ram (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (acc && (ram_wr || ram_rd)),
        .we       (ram_wr),
        .addr     (bus_a[AW-1:0]),
        .wdata    (wdata),
        .q        (mem_q),
        .clearing (busy)
    );

    cbd_pads u_pads (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (pad_req),
        .rd_bit (pad_bit)
    );

    always_comb
    begin
        tgt_n       = TGT_NONE;
        off_n       = '0;
        rdata_n     = '0;
        cstep_n     = 1'b0;
        astep_n     = 1'b0;
        oamv_n      = 1'b0;
        oamd_n      = '0;
        raddr_n     = '0;
        dma_rd      = 1'b0;
        rd_go       = 1'b0;
        ram_rd      = 1'b0;
        bus_a       = addr;
        page_next   = page_reg;
        offset_next = offset_reg;
        active_next = active_reg;
        align_next  = align_reg;
        phase_next  = phase_reg;
        pad_req     = '0;
        pad_req.idx     = pad_index;
        pad_req.mask    = button_mask;
        pad_req.pressed = pressed;
        pad_req.wbit    = wdata[0];

        unique case (act)
            ACT_READ:
            begin
                rd_go = 1'b1;
            end
            ACT_WRITE:
            begin
                priority if (ext_claim)
                begin
                    tgt_n = TGT_CART;
                end
                else if (addr <= RAM_TOP)
                begin
                    tgt_n = TGT_RAM;
                end
                else if (addr <= PPU_TOP)
                begin
                    tgt_n = TGT_PPU;
                    off_n = {2'b00, addr[2:0]};
                end
                else if (addr == DMA_REG_ADDR)
                begin
                    tgt_n       = TGT_DMA;
                    page_next   = wdata;
                    offset_next = '0;
                    active_next = 1'b1;
                    align_next  = 1'b1;
                end
                else if (addr == PAD0_ADDR)
                begin
                    tgt_n      = TGT_PAD;
                    pad_req.wr = acc;
                end
                else if (addr >= APU_BASE && addr <= PAD1_ADDR)
                begin
                    tgt_n = TGT_APU;
                    off_n = addr[4:0];
                end
                else
                begin
                    tgt_n = TGT_NONE;
                end
            end
            ACT_TICK:
            begin
                if (phase_reg == PHASE_A || phase_reg == PHASE_B)
                begin
                    astep_n = 1'b1;
                    if (active_reg)
                    begin
                        priority if (align_reg)
                        begin
                            if (phase_reg == PHASE_B)
                            begin
                                align_next = 1'b0;
                            end
                        end
                        else if (phase_reg == PHASE_A)
                        begin
                            dma_rd  = 1'b1;
                            rd_go   = 1'b1;
                            bus_a   = {page_reg, offset_reg};
                            raddr_n = {page_reg, offset_reg};
                        end
                        else
                        begin
                            oamv_n      = 1'b1;
                            oamd_n      = latch_reg;
                            offset_next = offset_reg + 8'd1;
                            if (offset_reg == DMA_LAST_OFF)
                            begin
                                active_next = 1'b0;
                                align_next  = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        cstep_n = 1'b1;
                    end
                end
                phase_next = (phase_reg >= PHASE_LAST) ? 3'd0 : phase_reg + 3'd1;
            end
            ACT_BUTTON:
            begin
                pad_req.upd = acc;
            end
            default:
            begin
                rd_go = 1'b0;
            end
        endcase

        pad_req.port = bus_a[0];
        if (rd_go)
        begin
            priority if (ext_claim)
            begin
                tgt_n   = TGT_CART;
                rdata_n = ext_data;
            end
            else if (bus_a <= RAM_TOP)
            begin
                tgt_n  = TGT_RAM;
                ram_rd = 1'b1;
            end
            else if (bus_a <= PPU_TOP)
            begin
                tgt_n   = TGT_PPU;
                off_n   = {2'b00, bus_a[2:0]};
                rdata_n = ext_data;
            end
            else if (bus_a == PAD0_ADDR || bus_a == PAD1_ADDR)
            begin
                tgt_n      = TGT_PAD;
                pad_req.rd = acc;
                rdata_n    = PAD_OPEN_BUS | {7'b0, pad_bit};
            end
            else if (bus_a == APU_STATUS)
            begin
                tgt_n   = TGT_APU;
                off_n   = APU_STAT_OFF;
                rdata_n = ext_data;
            end
            else
            begin
                tgt_n = TGT_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= '0;
            page_reg   <= '0;
            offset_reg <= '0;
            latch_reg  <= '0;
            active_reg <= 1'b0;
            align_reg  <= 1'b1;
            fix_reg    <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= acc;
            fix_reg  <= acc && dma_rd && ram_rd;
            if (acc)
            begin
                phase_reg  <= phase_next;
                page_reg   <= page_next;
                offset_reg <= offset_next;
                active_reg <= active_next;
                align_reg  <= align_next;
            end
            priority if (acc && dma_rd)
            begin
                latch_reg <= rdata_n;
            end
            else if (fix_reg)
            begin
                latch_reg <= mem_q;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            ram_sel_reg <= ram_rd;
            rdata_reg   <= rdata_n;
            tgt_reg     <= tgt_n;
            off_reg     <= off_n;
            cstep_reg   <= cstep_n;
            astep_reg   <= astep_n;
            oamv_reg    <= oamv_n;
            oamd_reg    <= oamd_n;
            raddr_reg   <= raddr_n;
            nmi_reg     <= (act == ACT_TICK) && ppu_nmi;
        end
    end

    assign done            = done_reg;
    assign rdata           = ram_sel_reg ? mem_q : rdata_reg;
    assign target          = tgt_reg;
    assign reg_offset      = off_reg;
    assign cpu_step        = cstep_reg;
    assign apu_step        = astep_reg;
    assign oam_write_valid = oamv_reg;
    assign oam_write_data  = oamd_reg;
    assign dma_read_addr   = raddr_reg;
    assign nmi_out         = nmi_reg;

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without accepted transaction");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result during ram clear");

    a_cpu_step_with_apu: assert property (@(posedge clk) disable iff (!rst_n)
        done && cpu_step |-> apu_step && !oam_write_valid)
        else $error("cpu step outside an apu phase or during dma write");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_LAST)
        else $error("tick phase out of range");

    a_dma_read_phase: assert property (@(posedge clk) disable iff (!rst_n)
        acc && dma_rd |-> active_reg && !align_reg && phase_reg == PHASE_A)
        else $error("dma read outside its phase");

endmodule
